>>> hw/rtl/lqfs_pkg.sv
// Shared types and constants of the log-quantize field sample block.
`default_nettype none

package lqfs_pkg;

	// Box geometry: columns at or beyond this count never add to the box sum
	localparam int BOX_WIDTH = 4;
	localparam int BOX_COLS  = 4;

	// Configuration register indexes
	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_LOG_GAIN       = 2'd0;
	localparam cfg_idx_t CFG_LOG_OFFSET     = 2'd1;
	localparam cfg_idx_t CFG_LIGHTNING_GAIN = 2'd2;

	// Register reset values
	localparam logic [7:0] LOG_GAIN_RST       = 8'd50;
	localparam logic [7:0] LOG_OFFSET_RST     = 8'd128;
	localparam logic [7:0] LIGHTNING_GAIN_RST = 8'd30;

	// Fixed-point log2: ten squaring steps give ten fraction bits
	localparam int SQ_STEPS   = 10;
	localparam int LOG_STAGES = SQ_STEPS + 2;
	localparam int L2_W       = 8 + SQ_STEPS;

	// log10(2) in Q.16, and 1e-6 in units of 2^-60
	localparam logic [14:0] LOG10_OF_2_Q16 = 15'd19728;
	localparam logic [63:0] EPS_Q60        = 64'd1152921504607;

	// Integer-part bias of the log2 inputs
	localparam logic signed [7:0] SMALL_BIAS = -8'sd60;
	localparam logic signed [7:0] FLASH_BIAS = -8'sd8;

	// Lanes of the log2 array
	localparam int LANE_CLOUD  = 0;
	localparam int LANE_RAIN   = 1;
	localparam int LANE_VAPOUR = 2;
	localparam int LANE_FLASH  = 3;
	localparam int NUM_SCALAR  = 3;
	localparam int NUM_LANES   = 4;

	// Widths of the quantizer
	localparam int K_W    = 23;
	localparam int PROD_W = 42;

	// One input item: one row of the lightning box plus the scalar samples
	typedef struct packed {
		logic [31:0] cloud_bits;
		logic [31:0] rain_bits;
		logic [31:0] vapour_bits;
		logic [31:0] flash_a;
		logic [31:0] flash_b;
		logic [31:0] flash_c;
		logic [31:0] flash_d;
		logic [3:0]  column_mask;
		logic        first_row;
		logic        final_row;
	} sample_t;

	// One result item
	typedef struct packed {
		logic [7:0] cloud_code;
		logic [7:0] rain_code;
		logic [7:0] flash_code;
		logic [7:0] vapour_code;
	} code_t;

endpackage

`default_nettype wire

>>> hw/rtl/lqfs_if.sv
// Valid/ready channels carrying sample items in and code items out.
`default_nettype none

interface lqfs_sample_if;
	logic              valid;
	logic              ready;
	lqfs_pkg::sample_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface lqfs_code_if;
	logic            valid;
	logic            ready;
	lqfs_pkg::code_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/lqfs_log2.sv
// Pipelined fixed-point log2 with a ten-bit fraction: normalise, then one squaring per stage.
`default_nettype none

module lqfs_log2 (
	input  wire logic                                clk,
	input  wire logic [lqfs_pkg::LOG_STAGES-1:0]     en,
	input  wire logic [63:0]                         v_in,
	input  wire logic signed [7:0]                   bias_in,
	output logic signed [lqfs_pkg::L2_W-1:0]         l2
);
	import lqfs_pkg::*;

	logic [5:0]        p_in;
	logic [63:0]       v_s0;
	logic [5:0]        p_s0;
	logic signed [7:0] bias_s0;
	logic [63:0]       norm_w;
	logic [8:0]        ip_w;

	// Mantissa, fraction and integer part per stage; entry 0 is the normalised value
	logic [31:0]          sq_m_s    [SQ_STEPS+1];
	logic [SQ_STEPS-1:0]  sq_frac_s [SQ_STEPS+1];
	logic [7:0]           sq_ip_s   [SQ_STEPS+1];

	// Find the leading one
	always_comb begin
		p_in = '0;
		for (int i = 0; i < 64; i++) begin
			if (v_in[i]) begin
				p_in = 6'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			v_s0    <= v_in;
			p_s0    <= p_in;
			bias_s0 <= bias_in;
		end
	end

	// Normalise to Q1.31 and fold the bias into the integer part
	assign norm_w = v_s0 << (6'd63 - p_s0);
	assign ip_w   = {3'b000, p_s0} + {bias_s0[7], bias_s0};

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sq_m_s[0]    <= norm_w[63:32];
			sq_frac_s[0] <= '0;
			sq_ip_s[0]   <= ip_w[7:0];
		end
	end

	// Square and compare, one fraction bit per stage
	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
		logic [63:0] sq_w;
		logic [32:0] t_w;

		assign sq_w = 64'(sq_m_s[i]) * 64'(sq_m_s[i]);
		assign t_w  = sq_w[63:31];

		always_ff @(posedge clk) begin
			if (en[i+2]) begin
				if (t_w[32]) begin
					sq_m_s[i+1]    <= t_w[32:1];
					sq_frac_s[i+1] <= {sq_frac_s[i][SQ_STEPS-2:0], 1'b1};
				end else begin
					sq_m_s[i+1]    <= t_w[31:0];
					sq_frac_s[i+1] <= {sq_frac_s[i][SQ_STEPS-2:0], 1'b0};
				end
				sq_ip_s[i+1] <= sq_ip_s[i];
			end
		end
	end

	assign l2 = {sq_ip_s[SQ_STEPS], sq_frac_s[SQ_STEPS]};

endmodule

`default_nettype wire

>>> hw/rtl/log_quantize_field_sample_core.sv
// Top level: box accumulation, four log2 lanes and byte quantizers for one field sample.
//
//  channel     dir  handshake         payload
//  sample_in   in   valid/ready       sample_t: scalar samples, box row, mask, row flags
//  code_out    out  valid/ready       code_t: cloud, rain, flash, vapour codes
//  cfg         in   cfg_we, no wait   cfg_index selects gain/offset register, cfg_data
//
// A row is taken every cycle unless code_out stalls; a final row's codes end in out_q.
// The box sum is updated in the third stage, so back-to-back rows of one box chain there.
// Rows that are neither first nor final leave the pipeline after that stage.
// A stalled output holds its item; upstream stages keep filling any empty slots.
// Reset clears the registers to their defaults, the box sum and the held codes.
`default_nettype none

module log_quantize_field_sample_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire lqfs_pkg::cfg_idx_t cfg_index,
	input  wire logic [7:0]         cfg_data,
	lqfs_sample_if.sink             sample_in,
	lqfs_code_if.source             code_out
);
	import lqfs_pkg::*;

	// Pipeline stage positions
	localparam int STG_IN   = 0;
	localparam int STG_PREP = 1;
	localparam int STG_ACC  = 2;
	localparam int STG_LOG0 = 3;
	localparam int STG_PROD = STG_LOG0 + LOG_STAGES;
	localparam int STG_CODE = STG_PROD + 1;
	localparam int NUM_STG  = STG_CODE + 1;

	logic [7:0] log_gain_q;
	logic [7:0] log_offset_q;
	logic [7:0] lightning_gain_q;
	logic [K_W-1:0] scal_k_q;
	logic [K_W-1:0] flash_k_q;

	logic [NUM_STG-1:0] vld_q;
	logic [NUM_STG-1:0] first_q;
	logic [NUM_STG-1:0] final_q;
	logic [NUM_STG-1:0] en_w;
	logic               en_out_w;

	sample_t           item_s1;
	logic [33:0]       row_w;
	logic [33:0]       row_s2;
	logic [63:0]       sv_w  [NUM_SCALAR];
	logic signed [7:0] sb_w  [NUM_SCALAR];
	logic [63:0]       sv_s2 [NUM_SCALAR];
	logic signed [7:0] sb_s2 [NUM_SCALAR];
	logic [63:0]       sv_s3 [NUM_SCALAR];
	logic signed [7:0] sb_s3 [NUM_SCALAR];

	logic [31:0] box_sum_q;
	logic [31:0] nsum_w;
	logic [31:0] box_s3;
	logic [32:0] fv_w;

	logic [63:0]              lv_w   [NUM_LANES];
	logic signed [7:0]        lb_w   [NUM_LANES];
	logic signed [L2_W-1:0]   l2_w   [NUM_LANES];
	logic signed [PROD_W-1:0] prod_w [NUM_LANES];
	logic signed [PROD_W-1:0] prod_s4 [NUM_LANES];
	logic signed [PROD_W-1:0] t_w    [NUM_LANES];
	logic [7:0]               code_s5 [NUM_LANES];

	logic [7:0] held_cloud_q;
	logic [7:0] held_rain_q;
	logic [7:0] held_vapour_q;
	code_t      out_q;
	logic       out_vld_q;

	// max(0,x) of one lightning value in saturating Q24.8
	function automatic logic [31:0] flash_q8(input logic [31:0] b);
		logic [7:0]  ex;
		logic [31:0] mant;
		logic [31:0] r;
		ex   = b[30:23];
		mant = {8'b0, 1'b1, b[22:0]};
		priority if (b[31]) begin
			r = '0;
		end else if (ex == 8'hFF) begin
			r = (b[22:0] != 23'd0) ? 32'd0 : '1;
		end else if (ex == 8'd0) begin
			r = '0;
		end else if (ex > 8'd150) begin
			r = '1;
		end else if (ex >= 8'd142) begin
			r = mant << (ex - 8'd142);
		end else if (ex <= 8'd110) begin
			r = '0;
		end else begin
			r = mant >> (8'd142 - ex);
		end
		return r;
	endfunction

	// Clamp a Q.26 value to a byte code
	function automatic logic [7:0] to_code(input logic signed [PROD_W-1:0] t);
		logic [PROD_W-27:0] q;
		logic [7:0]         c;
		q = t[PROD_W-1:26];
		if (t <= 0) begin
			c = 8'd0;
		end else if (q > 16'd255) begin
			c = 8'd255;
		end else begin
			c = q[7:0];
		end
		return c;
	endfunction

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_gain_q       <= LOG_GAIN_RST;
			log_offset_q     <= LOG_OFFSET_RST;
			lightning_gain_q <= LIGHTNING_GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOG_GAIN:       log_gain_q       <= cfg_data;
				CFG_LOG_OFFSET:     log_offset_q     <= cfg_data;
				CFG_LIGHTNING_GAIN: lightning_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pre-scale the gains by log10(2)
	always_ff @(posedge clk) begin
		scal_k_q  <= K_W'(log_gain_q) * K_W'(LOG10_OF_2_Q16);
		flash_k_q <= K_W'(lightning_gain_q) * K_W'(LOG10_OF_2_Q16);
	end

	// Stage enables: a stage loads when empty or when its successor moves
	always_comb begin
		en_out_w = !out_vld_q || code_out.ready;
		en_w[NUM_STG-1] = !vld_q[NUM_STG-1] || en_out_w;
		for (int k = NUM_STG - 2; k >= 0; k--) begin
			en_w[k] = !vld_q[k] || en_w[k+1];
		end
	end

	assign sample_in.ready = en_w[STG_IN];

	// Advance valid bits; drop rows that neither latch nor emit after accumulation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en_w[STG_IN]) begin
				vld_q[STG_IN] <= sample_in.valid;
			end
			for (int k = 1; k < NUM_STG; k++) begin
				if (en_w[k]) begin
					if (k == STG_LOG0) begin
						vld_q[k] <= vld_q[k-1] && (first_q[k-1] || final_q[k-1]);
					end else begin
						vld_q[k] <= vld_q[k-1];
					end
				end
			end
		end
	end

	// Advance row flags
	always_ff @(posedge clk) begin
		if (en_w[STG_IN]) begin
			first_q[STG_IN] <= sample_in.item.first_row;
			final_q[STG_IN] <= sample_in.item.final_row;
		end
		for (int k = 1; k < NUM_STG; k++) begin
			if (en_w[k]) begin
				first_q[k] <= first_q[k-1];
				final_q[k] <= final_q[k-1];
			end
		end
	end

	// Convert the row's valid columns and add them
	always_comb begin
		logic [31:0] col [BOX_COLS];
		col[0] = item_s1.flash_a;
		col[1] = item_s1.flash_b;
		col[2] = item_s1.flash_c;
		col[3] = item_s1.flash_d;
		row_w = '0;
		for (int c = 0; c < BOX_COLS; c++) begin
			if (item_s1.column_mask[c] && (c < BOX_WIDTH)) begin
				row_w = row_w + {2'b00, flash_q8(col[c])};
			end
		end
	end

	// Form |x|+1e-6 on the 2^-60 grid for small values, the bare mantissa otherwise
	always_comb begin
		logic [31:0] b [NUM_SCALAR];
		logic [7:0]  ex;
		logic [7:0]  exs;
		logic [22:0] fr;
		logic [63:0] mant;
		logic [7:0]  ls;
		logic [7:0]  rs;
		b[LANE_CLOUD]  = item_s1.cloud_bits;
		b[LANE_RAIN]   = item_s1.rain_bits;
		b[LANE_VAPOUR] = item_s1.vapour_bits;
		for (int l = 0; l < NUM_SCALAR; l++) begin
			ex = b[l][30:23];
			fr = b[l][22:0];
			if (ex == 8'hFF) begin
				ex = 8'hFE;
				fr = '1;
			end
			mant = {40'b0, (ex != 8'd0), fr};
			exs  = (ex == 8'd0) ? 8'd1 : ex;
			ls   = exs - 8'd90;
			rs   = 8'd90 - exs;
			if (ex < 8'd130) begin
				if (exs >= 8'd90) begin
					sv_w[l] = (mant << ls[5:0]) + EPS_Q60;
				end else begin
					sv_w[l] = (mant >> rs[6:0]) + EPS_Q60;
				end
				sb_w[l] = SMALL_BIAS;
			end else begin
				sv_w[l] = mant;
				sb_w[l] = $signed(ex - 8'd150);
			end
		end
	end

	// Add the row to the box sum, saturating
	always_comb begin
		logic [31:0] base;
		logic [34:0] tot;
		base   = first_q[STG_PREP] ? 32'd0 : box_sum_q;
		tot    = {3'b000, base} + {1'b0, row_s2};
		nsum_w = (tot[34:32] != 3'b000) ? '1 : tot[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_sum_q <= '0;
		end else if (en_w[STG_ACC] && vld_q[STG_PREP]) begin
			box_sum_q <= nsum_w;
		end
	end

	// Front stage registers
	always_ff @(posedge clk) begin
		if (en_w[STG_IN]) begin
			item_s1 <= sample_in.item;
		end
		if (en_w[STG_PREP]) begin
			row_s2 <= row_w;
			sv_s2  <= sv_w;
			sb_s2  <= sb_w;
		end
		if (en_w[STG_ACC]) begin
			box_s3 <= nsum_w;
			sv_s3  <= sv_s2;
			sb_s3  <= sb_s2;
		end
	end

	// Log2 lanes: three scalars and box sum plus one
	assign fv_w = {1'b0, box_s3} + 33'd256;

	always_comb begin
		for (int l = 0; l < NUM_SCALAR; l++) begin
			lv_w[l] = sv_s3[l];
			lb_w[l] = sb_s3[l];
		end
		lv_w[LANE_FLASH] = {31'b0, fv_w};
		lb_w[LANE_FLASH] = FLASH_BIAS;
	end

	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		lqfs_log2 u_log2 (
			.clk     (clk),
			.en      (en_w[STG_LOG0 +: LOG_STAGES]),
			.v_in    (lv_w[l]),
			.bias_in (lb_w[l]),
			.l2      (l2_w[l])
		);
	end

	// Scale by gain*log10(2), then add the offset on the scalar lanes and clamp
	always_comb begin
		for (int l = 0; l < NUM_LANES; l++) begin
			if (l == LANE_FLASH) begin
				prod_w[l] = $signed({1'b0, flash_k_q}) * l2_w[l];
				t_w[l]    = prod_s4[l];
			end else begin
				prod_w[l] = $signed({1'b0, scal_k_q}) * l2_w[l];
				t_w[l]    = prod_s4[l] + $signed({8'b0, log_offset_q, 26'b0});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_w[STG_PROD]) begin
			prod_s4 <= prod_w;
		end
		if (en_w[STG_CODE]) begin
			for (int l = 0; l < NUM_LANES; l++) begin
				code_s5[l] <= to_code(t_w[l]);
			end
		end
	end

	// Latch scalar codes on a first row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cloud_q  <= '0;
			held_rain_q   <= '0;
			held_vapour_q <= '0;
			out_vld_q     <= 1'b0;
		end else if (en_out_w) begin
			if (vld_q[STG_CODE] && first_q[STG_CODE]) begin
				held_cloud_q  <= code_s5[LANE_CLOUD];
				held_rain_q   <= code_s5[LANE_RAIN];
				held_vapour_q <= code_s5[LANE_VAPOUR];
			end
			out_vld_q <= vld_q[STG_CODE] && final_q[STG_CODE];
		end
	end

	// Output register: codes of a final row
	always_ff @(posedge clk) begin
		if (en_out_w) begin
			out_q.cloud_code  <= first_q[STG_CODE] ? code_s5[LANE_CLOUD] : held_cloud_q;
			out_q.rain_code   <= first_q[STG_CODE] ? code_s5[LANE_RAIN] : held_rain_q;
			out_q.vapour_code <= first_q[STG_CODE] ? code_s5[LANE_VAPOUR] : held_vapour_q;
			out_q.flash_code  <= code_s5[LANE_FLASH];
		end
	end

	assign code_out.valid = out_vld_q;
	assign code_out.item  = out_q;

endmodule

`default_nettype wire
